/* src/rsfp_pkg.sv */
// rsfp_pkg: frame byte codes and the result type of the sensor frame parser
`timescale 1ns / 1ps
package rsfp_pkg;

	// frame byte codes
	localparam logic [7:0] START_BYTE   = 8'h02;
	localparam logic [7:0] HEADER_ONE   = 8'h10;
	localparam logic [7:0] HEADER_TWO   = 8'h04;
	localparam logic [7:0] SHOCK_STATUS = 8'hE0;
	localparam logic [7:0] SUM_GOOD     = 8'hFF;
	localparam logic [6:0] HIGH_SCALE   = 7'd100;

	localparam int unsigned READING_W = 15;

	typedef struct packed {
		logic [READING_W-1:0] concentration;
		logic [7:0]           elapsed_minutes;
		logic [1:0]           up_code;
		logic                 shocked;
		logic                 checksum_ok;
	} result_t;

endpackage

/* src/radon_sensor_frame_parser_unit.sv */
// radon_sensor_frame_parser_unit: eight-byte sensor frame parser, one byte per beat
`timescale 1ns / 1ps
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------------
//  rx      | in        | rx_valid / rx_stall | rx_byte
//  res     | out       | res_valid/res_stall | concentration, elapsed_minutes, up_code,
//          |           |                     | shocked, checksum_ok
//
//  a byte is taken every cycle while rx_stall is low: it lands in the input register, is
//  parsed from there by one compare, an 8-bit add and an 8x7 multiply, and a frame result
//  is written into the output register as the checksum byte is parsed
//  arst_n clears the parser position, the running sum, the held fields and both valids
//  rx_stall rises only when the checksum byte waits in the input register and the
//  output register still holds an untaken result; other bytes never wait
//
module radon_sensor_frame_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// frame result output
	output logic        res_valid,
	input  logic        res_stall,
	output logic [14:0] concentration,
	output logic [7:0]  elapsed_minutes,
	output logic [1:0]  up_code,
	output logic        shocked,
	output logic        checksum_ok
);

	// parser positions
	localparam logic [2:0] POS_IDLE     = 3'd0;
	localparam logic [2:0] POS_HEADER1  = 3'd1;
	localparam logic [2:0] POS_HEADER2  = 3'd2;
	localparam logic [2:0] POS_STATUS   = 3'd3;
	localparam logic [2:0] POS_ELAPSED  = 3'd4;
	localparam logic [2:0] POS_HIGH     = 3'd5;
	localparam logic [2:0] POS_LOW      = 3'd6;
	localparam logic [2:0] POS_CHECKSUM = 3'd7;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	logic [2:0]  pos_q;
	logic [7:0]  sum_q;
	logic [14:0] reading_q;
	logic [7:0]  elapsed_q;
	logic [1:0]  up_q;
	logic        shock_q;

	// output register
	logic              res_valid_q;
	rsfp_pkg::result_t res_q;

	logic              advance;
	logic              emit;
	logic [7:0]        sum_next;
	logic [14:0]       high_scaled;
	logic [2:0]        pos_d;
	logic [7:0]        sum_d;
	rsfp_pkg::result_t res_d;

	// only the checksum beat needs room in the output register
	assign advance  = !(pos_q == POS_CHECKSUM && res_valid_q && res_stall);
	assign emit     = valid_s1 && advance && pos_q == POS_CHECKSUM;
	assign rx_stall = valid_s1 && !advance;

	assign sum_next    = sum_q + byte_s1;
	// both operands widened so the product keeps all of its bits
	assign high_scaled = 15'(byte_s1) * 15'(rsfp_pkg::HIGH_SCALE);

	// next position and running sum
	always_comb begin
		pos_d = pos_q;
		sum_d = sum_q;
		unique case (pos_q)
			POS_IDLE: begin
				if (byte_s1 == rsfp_pkg::START_BYTE) begin
					pos_d = POS_HEADER1;
					sum_d = '0;
				end
			end
			POS_HEADER1: begin
				if (byte_s1 == rsfp_pkg::HEADER_ONE) begin
					pos_d = POS_HEADER2;
					sum_d = sum_next;
				end else begin
					pos_d = POS_IDLE;
				end
			end
			POS_HEADER2: begin
				if (byte_s1 == rsfp_pkg::HEADER_TWO) begin
					pos_d = POS_STATUS;
					sum_d = sum_next;
				end else begin
					pos_d = POS_IDLE;
				end
			end
			POS_CHECKSUM: begin
				pos_d = POS_IDLE;
				sum_d = sum_next;
			end
			default: begin
				// status, elapsed, high and low bytes all add and step on
				pos_d = pos_q + 3'd1;
				sum_d = sum_next;
			end
		endcase
	end

	always_comb begin
		res_d.concentration   = reading_q;
		res_d.elapsed_minutes = elapsed_q;
		res_d.up_code         = up_q;
		res_d.shocked         = shock_q;
		res_d.checksum_ok     = (sum_next == rsfp_pkg::SUM_GOOD);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_IDLE;
			sum_q     <= '0;
			reading_q <= '0;
			elapsed_q <= '0;
			up_q      <= '0;
			shock_q   <= 1'b0;
		end else if (valid_s1 && advance) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
			if (pos_q == POS_STATUS) begin
				shock_q <= (byte_s1 == rsfp_pkg::SHOCK_STATUS);
				up_q    <= byte_s1[1:0];
			end
			if (pos_q == POS_ELAPSED) begin
				elapsed_q <= byte_s1;
			end
			if (pos_q == POS_HIGH) begin
				reading_q <= high_scaled;
			end
			if (pos_q == POS_LOW) begin
				reading_q <= reading_q + 15'(byte_s1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid       = res_valid_q;
	assign concentration   = res_q.concentration;
	assign elapsed_minutes = res_q.elapsed_minutes;
	assign up_code         = res_q.up_code;
	assign shocked         = res_q.shocked;
	assign checksum_ok     = res_q.checksum_ok;

	// a new result only follows a parsed checksum beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pos_q) == POS_CHECKSUM && $past(valid_s1))
		else $error("result raised without a checksum beat");

	// a parsed checksum beat always leaves a result and returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> res_valid && pos_q == POS_IDLE)
		else $error("checksum beat lost its result");

	// input backpressure only comes from a blocked output register
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> res_valid && res_stall && pos_q == POS_CHECKSUM)
		else $error("input stalled without cause");

endmodule
